// ===== rtl/ecu_smam_pkg.sv =====
// ---------------------------------------------------------------------------
// ecu_smam_pkg
// Shared types, codes and byte-format helpers for the serial memory access
// master.
// ---------------------------------------------------------------------------
`default_nettype none

package ecu_smam_pkg;

  // Chunk sizing
  localparam logic [15:0] SMALL_CHUNK  = 16'd16;
  localparam int          WINDOW_BYTES = 64;
  localparam int          WIN_LSB      = $clog2(WINDOW_BYTES);
  localparam int          WIN_W        = 16 - WIN_LSB;

  // Fixed prefixes of the read and write command bytes
  localparam logic [1:0] READ_PREFIX  = 2'b11;
  localparam logic [1:0] WRITE_PREFIX = 2'b10;

  // Result queue depth
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RX      = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_DATA = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_ECHO    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_R_ECHO1 = 3'd1,
    PH_R_ECHO2 = 3'd2,
    PH_R_DATA  = 3'd3,
    PH_W_ECHO1 = 3'd4,
    PH_W_ECHO2 = 3'd5,
    PH_W_ECHO3 = 3'd6,
    PH_W_ECHO4 = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    CFG_SIZE_A = 3'd0,
    CFG_SIZE_B = 3'd1,
    CFG_SIZE_C = 3'd2,
    CFG_SIZE_D = 3'd3,
    CFG_CODE_A = 3'd4,
    CFG_CODE_B = 3'd5,
    CFG_CODE_C = 3'd6,
    CFG_CODE_D = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [15:0] length;
    logic [7:0]  write_value;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] size_a;
    logic [15:0] size_b;
    logic [15:0] size_c;
    logic [15:0] size_d;
    logic [4:0]  code_a;
    logic [4:0]  code_b;
    logic [4:0]  code_c;
    logic [4:0]  code_d;
  } cfg_t;

  // First preset from size_d to size_a that fits, else small chunk or the rest
  function automatic logic [15:0] pick_chunk(logic [15:0] left, cfg_t c);
    logic [15:0] r;
    if (c.size_d != '0 && left >= c.size_d) r = c.size_d;
    else if (c.size_c != '0 && left >= c.size_c) r = c.size_c;
    else if (c.size_b != '0 && left >= c.size_b) r = c.size_b;
    else if (c.size_a != '0 && left >= c.size_a) r = c.size_a;
    else if (left >= SMALL_CHUNK) r = SMALL_CHUNK;
    else r = left;
    return r;
  endfunction

  // Quantity code carried in the first coarse byte
  function automatic logic [4:0] quantity_code(logic [15:0] n, cfg_t c);
    logic [15:0] nm1;
    logic [4:0]  r;
    nm1 = n - 16'd1;
    if (n == '0) r = '0;
    else if (n <= SMALL_CHUNK) r = nm1[4:0];
    else if (n == c.size_a) r = c.code_a;
    else if (n == c.size_b) r = c.code_b;
    else if (n == c.size_c) r = c.code_c;
    else if (n == c.size_d) r = c.code_d;
    else r = '0;
    return r;
  endfunction

  function automatic logic [7:0] first_byte(logic [15:0] a, logic [4:0] code);
    return {1'b0, code, a[15:14]};
  endfunction

  function automatic logic [7:0] second_byte(logic [15:0] a);
    return a[13:6];
  endfunction

  function automatic logic [7:0] read_byte(logic [15:0] a);
    return {READ_PREFIX, a[5:0]};
  endfunction

  function automatic logic [7:0] write_byte(logic [15:0] a);
    return {WRITE_PREFIX, a[5:0]};
  endfunction

  function automatic out_item_t mk_result(kind_t k, logic [7:0] b, status_t s);
    out_item_t r;
    r.kind       = k;
    r.byte_value = b;
    r.status     = s;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ecu_smam_cfg.sv =====
// ---------------------------------------------------------------------------
// ecu_smam_cfg
// Register file for the preset chunk sizes and their quantity codes.
// ---------------------------------------------------------------------------
`default_nettype none

module ecu_smam_cfg (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [2:0]               cfg_index,
  input  wire  [15:0]              cfg_data,
  output ecu_smam_pkg::cfg_t       cfg
);
  import ecu_smam_pkg::*;

  cfg_t cfg_r;

  // Always able to take a register write
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Update the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_a <= 16'd64;
      cfg_r.size_b <= 16'd256;
      cfg_r.size_c <= 16'd1024;
      cfg_r.size_d <= 16'd4096;
      cfg_r.code_a <= 5'd16;
      cfg_r.code_b <= 5'd17;
      cfg_r.code_c <= 5'd18;
      cfg_r.code_d <= 5'd19;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SIZE_A: cfg_r.size_a <= cfg_data;
        CFG_SIZE_B: cfg_r.size_b <= cfg_data;
        CFG_SIZE_C: cfg_r.size_c <= cfg_data;
        CFG_SIZE_D: cfg_r.size_d <= cfg_data;
        CFG_CODE_A: cfg_r.code_a <= cfg_data[4:0];
        CFG_CODE_B: cfg_r.code_b <= cfg_data[4:0];
        CFG_CODE_C: cfg_r.code_c <= cfg_data[4:0];
        CFG_CODE_D: cfg_r.code_d <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ecu_smam_core.sv =====
// ---------------------------------------------------------------------------
// ecu_smam_core
// Request register, protocol state and the single-pass step logic that
// turns one input item into up to two results.
// ---------------------------------------------------------------------------
`default_nettype none

module ecu_smam_core (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire ecu_smam_pkg::in_item_t in_data,
  input  wire ecu_smam_pkg::cfg_t     cfg,
  input  wire                         room,
  output logic [1:0]                  push_n,
  output ecu_smam_pkg::out_item_t     push0,
  output ecu_smam_pkg::out_item_t     push1
);
  import ecu_smam_pkg::*;

  // Request register
  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     proc;

  // Protocol state
  phase_t             phase_r,  phase_nxt;
  logic [15:0]        addr_r,   addr_nxt;
  logic [15:0]        left_r,   left_nxt;
  logic [15:0]        csize_r,  csize_nxt;
  logic [15:0]        crecv_r,  crecv_nxt;
  logic [7:0]         echo_r,   echo_nxt;
  logic [7:0]         pend_r,   pend_nxt;
  logic [WIN_W-1:0]   cwin_r,   cwin_nxt;
  logic [15:0]        csz_r,    csz_nxt;

  // Step results
  out_item_t   res0, res1;
  logic [1:0]  res_n;

  // Data phase helpers
  logic [15:0] addr_inc, left_dec, crecv_inc;

  // Chunk start helpers
  logic [15:0] sc_addr, sc_left, sc_cs, sc_chunk;
  logic        sc_hit;
  logic [7:0]  sc_byte;

  assign proc     = s1_valid_r && room;
  assign in_ready = !s1_valid_r || proc;

  // Hold the request until the result queue has room for two results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  assign addr_inc  = addr_r + 16'd1;
  assign left_dec  = (left_r != '0) ? left_r - 16'd1 : left_r;
  assign crecv_inc = crecv_r + 16'd1;

  // Choose the next chunk and decide whether the coarse address is skipped
  always_comb begin
    if (phase_r == PH_R_DATA) begin
      sc_addr = addr_inc;
      sc_left = left_dec;
      sc_cs   = csize_r;
    end else begin
      sc_addr = s1_item_r.address;
      sc_left = s1_item_r.length;
      sc_cs   = csz_r;
    end
    sc_chunk = pick_chunk(sc_left, cfg);
    sc_hit   = (sc_cs != '0) && (sc_chunk == sc_cs) &&
               (sc_addr[15:WIN_LSB] == cwin_r);
    sc_byte  = sc_hit ? read_byte(sc_addr)
                      : first_byte(sc_addr, quantity_code(sc_chunk, cfg));
  end

  // Step the protocol for the registered request
  always_comb begin
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    csize_nxt = csize_r;
    crecv_nxt = crecv_r;
    echo_nxt  = echo_r;
    pend_nxt  = pend_r;
    cwin_nxt  = cwin_r;
    csz_nxt   = csz_r;
    res0      = '0;
    res1      = '0;
    res_n     = 2'd0;

    if (phase_r == PH_IDLE) begin
      if (s1_item_r.cmd == CMD_READ) begin
        addr_nxt = s1_item_r.address;
        left_nxt = s1_item_r.length;
        res_n    = 2'd1;
        if (s1_item_r.length == '0) begin
          res0 = mk_result(KIND_DONE, 8'h00, ST_OK);
        end else begin
          csize_nxt = sc_chunk;
          crecv_nxt = '0;
          res0      = mk_result(KIND_TX, sc_byte, ST_OK);
          if (sc_hit) begin
            phase_nxt = PH_R_DATA;
          end else begin
            echo_nxt  = sc_byte;
            phase_nxt = PH_R_ECHO1;
          end
        end
      end else if (s1_item_r.cmd == CMD_WRITE) begin
        csz_nxt   = '0;
        cwin_nxt  = '0;
        addr_nxt  = s1_item_r.address;
        pend_nxt  = s1_item_r.write_value;
        echo_nxt  = first_byte(s1_item_r.address, 5'd0);
        res0      = mk_result(KIND_TX, first_byte(s1_item_r.address, 5'd0), ST_OK);
        phase_nxt = PH_W_ECHO1;
        res_n     = 2'd1;
      end
    end else if (s1_item_r.cmd == CMD_TIMEOUT) begin
      // Abort on timeout
      csz_nxt   = '0;
      cwin_nxt  = '0;
      phase_nxt = PH_IDLE;
      res0      = mk_result(KIND_DONE, 8'h00, ST_TIMEOUT);
      res_n     = 2'd1;
    end else if (s1_item_r.cmd == CMD_RX) begin
      res_n = 2'd1;
      if (phase_r == PH_R_DATA) begin
        // Pass data on, close the chunk when it is full
        res0      = mk_result(KIND_DATA, s1_item_r.rx_byte, ST_OK);
        crecv_nxt = crecv_inc;
        addr_nxt  = addr_inc;
        left_nxt  = left_dec;
        if (crecv_inc >= csize_r) begin
          csz_nxt = csize_r;
          res_n   = 2'd2;
          if (left_dec == '0) begin
            phase_nxt = PH_IDLE;
            res1      = mk_result(KIND_DONE, 8'h00, ST_OK);
          end else begin
            csize_nxt = sc_chunk;
            crecv_nxt = '0;
            res1      = mk_result(KIND_TX, sc_byte, ST_OK);
            if (sc_hit) begin
              phase_nxt = PH_R_DATA;
            end else begin
              echo_nxt  = sc_byte;
              phase_nxt = PH_R_ECHO1;
            end
          end
        end
      end else if (s1_item_r.rx_byte != echo_r) begin
        // Drop the request on a bad echo
        csz_nxt   = '0;
        cwin_nxt  = '0;
        phase_nxt = PH_IDLE;
        res0      = mk_result(KIND_DONE, 8'h00, ST_ECHO);
      end else begin
        unique case (phase_r)
          PH_R_ECHO1, PH_W_ECHO1: begin
            echo_nxt  = second_byte(addr_r);
            res0      = mk_result(KIND_TX, second_byte(addr_r), ST_OK);
            phase_nxt = (phase_r == PH_R_ECHO1) ? PH_R_ECHO2 : PH_W_ECHO2;
          end
          PH_R_ECHO2: begin
            cwin_nxt  = addr_r[15:WIN_LSB];
            res0      = mk_result(KIND_TX, read_byte(addr_r), ST_OK);
            phase_nxt = PH_R_DATA;
          end
          PH_W_ECHO2: begin
            echo_nxt  = write_byte(addr_r);
            res0      = mk_result(KIND_TX, write_byte(addr_r), ST_OK);
            phase_nxt = PH_W_ECHO3;
          end
          PH_W_ECHO3: begin
            echo_nxt  = pend_r;
            res0      = mk_result(KIND_TX, pend_r, ST_OK);
            phase_nxt = PH_W_ECHO4;
          end
          default: begin
            phase_nxt = PH_IDLE;
            res0      = mk_result(KIND_DONE, 8'h00, ST_OK);
          end
        endcase
      end
    end

    // Mark the final result of this request
    if (res_n == 2'd1) res0.last = 1'b1;
    if (res_n == 2'd2) res1.last = 1'b1;
  end

  assign push_n = proc ? res_n : 2'd0;
  assign push0  = res0;
  assign push1  = res1;

  // Advance the protocol state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      addr_r  <= '0;
      left_r  <= '0;
      csize_r <= '0;
      crecv_r <= '0;
      echo_r  <= '0;
      pend_r  <= '0;
      cwin_r  <= '0;
      csz_r   <= '0;
    end else if (proc) begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      left_r  <= left_nxt;
      csize_r <= csize_nxt;
      crecv_r <= crecv_nxt;
      echo_r  <= echo_nxt;
      pend_r  <= pend_nxt;
      cwin_r  <= cwin_nxt;
      csz_r   <= csz_nxt;
    end
  end

  // An open chunk never holds as many bytes as its size
  a_chunk_open: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_R_DATA |-> crecv_r < csize_r)
    else $error("chunk receive count reached chunk size in data phase");

  // Only the final result of a step carries last
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    push_n == 2'd2 |-> !push0.last && push1.last)
    else $error("last marking wrong on two-result step");

  // A failed request leaves no cached window
  a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push_n == 2'd1 && push0.kind == KIND_DONE && push0.status != ST_OK
    |=> csz_r == '0 && phase_r == PH_IDLE)
    else $error("cache not cleared after aborted request");

  // A step that finishes the request ends in idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    push_n == 2'd2 && push1.kind == KIND_DONE |=> phase_r == PH_IDLE)
    else $error("phase not idle after read completion");

endmodule

`default_nettype wire

// ===== rtl/ecu_smam_outq.sv =====
// ---------------------------------------------------------------------------
// ecu_smam_outq
// Small shifting result queue: takes up to two results a cycle while it has
// room, hands out one a cycle on the result channel while out_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none

module ecu_smam_outq (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [1:0]                   push_n,
  input  wire ecu_smam_pkg::out_item_t push0,
  input  wire ecu_smam_pkg::out_item_t push1,
  output logic                         room,
  output logic                         out_valid,
  input  wire                          out_ready,
  output ecu_smam_pkg::out_item_t      out_data
);
  import ecu_smam_pkg::*;

  out_item_t              slot_r [OUTQ_DEPTH];
  out_item_t              slot_nxt [OUTQ_DEPTH];
  logic [OUTQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [OUTQ_CNT_W-1:0]  cnt_pop;
  logic                   pop;

  assign out_valid = cnt_r != '0;
  assign out_data  = slot_r[0];
  assign pop       = out_valid && out_ready;
  assign room      = cnt_r <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
  assign cnt_pop   = cnt_r - OUTQ_CNT_W'(pop);
  assign cnt_nxt   = cnt_pop + OUTQ_CNT_W'(push_n);

  // Shift on pop, append new results behind the survivors
  always_comb begin
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    if (pop) begin
      for (int i = 0; i < OUTQ_DEPTH - 1; i++) begin
        slot_nxt[i] = slot_r[i + 1];
      end
    end
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      if (push_n != 2'd0 && OUTQ_CNT_W'(i) == cnt_pop) slot_nxt[i] = push0;
      if (push_n == 2'd2 && OUTQ_CNT_W'(i) == cnt_pop + OUTQ_CNT_W'(1)) slot_nxt[i] = push1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Never filled beyond its depth
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OUTQ_CNT_W'(OUTQ_DEPTH))
    else $error("result queue overflow");

  // Results arrive only when room was granted
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |-> room)
    else $error("push into result queue without room");

  // Count tracks pushes and pops
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    !pop && push_n == 2'd0 |=> $stable(cnt_r))
    else $error("result count changed without traffic");

endmodule

`default_nettype wire

// ===== rtl/ecu_serial_memory_access_master_unit.sv =====
// ---------------------------------------------------------------------------
// ecu_serial_memory_access_master_unit
// Byte-serial memory access master: read and write requests in, transmit
// bytes, read data and completion out.
// ---------------------------------------------------------------------------
// Each accepted item (request, received byte or timeout) is registered and
// handled once the four-entry result queue holds at most two results; its
// one or two results are queued for the result channel. Items are taken one
// per clock under that condition; an item at the end of a read chunk gives
// two results, so a long run of those drains at one result per clock while
// out_ready is high. Configuration registers are written one per clock.
`default_nettype none

module ecu_serial_memory_access_master_unit (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire ecu_smam_pkg::in_item_t in_data,
  output logic                        out_valid,
  input  wire                         out_ready,
  output ecu_smam_pkg::out_item_t     out_data,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [2:0]                  cfg_index,
  input  wire  [15:0]                 cfg_data
);
  import ecu_smam_pkg::*;

  cfg_t       cfg;
  logic       room;
  logic [1:0] push_n;
  out_item_t  push0, push1;

  // Configuration registers
  ecu_smam_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Protocol step
  ecu_smam_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .room     (room),
    .push_n   (push_n),
    .push0    (push0),
    .push1    (push1)
  );

  // Result queue
  ecu_smam_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (push0),
    .push1     (push1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
